FILE: hdl/shfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfp_pkg
// Shared types and constants for the sync header frame parser.
// ----------------------------------------------------------------------------
package shfp_pkg;

    localparam logic [7:0] FIRST_SYNC_RESET  = 8'h55;
    localparam logic [7:0] SECOND_SYNC_RESET = 8'hAA;
    localparam logic [7:0] HUNT_LIMIT_RESET  = 8'd32;
    localparam logic [7:0] MISMATCH_OFFSET   = 8'h10;

    localparam int unsigned CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FIRST_SYNC  = 2'd0,
        REG_SECOND_SYNC = 2'd1,
        REG_HUNT_LIMIT  = 2'd2,
        REG_UNUSED      = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD      = 2'd0,
        KIND_FRAME_END    = 2'd1,
        KIND_FIRST_TIMEOUT  = 2'd2,
        KIND_SECOND_TIMEOUT = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] command_code;
        logic [7:0] algorithm_code;
        logic [7:0] payload_length;
        logic [7:0] received_sum;
        logic [7:0] computed_sum;
        logic       sum_matches;
        logic       last;
    } result_t;

endpackage

FILE: hdl/shfp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfp_if
// Handshake channels of the sync header frame parser: received bytes,
// results and register writes.
// ----------------------------------------------------------------------------
interface shfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface shfp_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] command_code;
    logic [7:0] algorithm_code;
    logic [7:0] payload_length;
    logic [7:0] received_sum;
    logic [7:0] computed_sum;
    logic       sum_matches;
    logic       last;

    modport source (output valid, output kind, output data_byte, output byte_index,
                    output command_code, output algorithm_code, output payload_length,
                    output received_sum, output computed_sum, output sum_matches,
                    output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input byte_index,
                    input command_code, input algorithm_code, input payload_length,
                    input received_sum, input computed_sum, input sum_matches,
                    input last, output ready);
endinterface

interface shfp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [shfp_pkg::CFG_INDEX_W-1:0] index;
    logic [7:0]                       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/sync_header_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_header_frame_parser
// Two-byte sync, length-prefixed frame parser with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
// One received byte is taken per clock. Each accepted byte updates the parser
// state in the same cycle and, when it produces a result (payload byte, frame
// end or hunt timeout), loads the result register, so a result word appears
// in the cycle after its byte. The rate is one byte per cycle; input ready drops
// only while the result register is full and the sink does not take it.
// Register writes are always accepted and act at once.
module sync_header_frame_parser (
    input  logic          clk,
    input  logic          rst_n,
    shfp_byte_if.sink     rx,
    shfp_result_if.source res,
    shfp_cfg_if.sink      cfg
);

    typedef enum logic [6:0] {
        PH_HUNT1 = 7'b0000001,
        PH_HUNT2 = 7'b0000010,
        PH_CMD   = 7'b0000100,
        PH_ALGO  = 7'b0001000,
        PH_LEN   = 7'b0010000,
        PH_DATA  = 7'b0100000,
        PH_SUM   = 7'b1000000
    } phase_t;

    logic [7:0] first_sync_reg;
    logic [7:0] second_sync_reg;
    logic [7:0] hunt_limit_reg;

    phase_t     phase_reg,    phase_next;
    logic [7:0] hunt_count_reg, hunt_count_next;
    logic [7:0] command_reg,  command_next;
    logic [7:0] algorithm_reg, algorithm_next;
    logic [7:0] length_reg,   length_next;
    logic [7:0] position_reg, position_next;
    logic [7:0] sum_reg,      sum_next;

    logic              accept;
    logic              space;
    logic              load;
    shfp_pkg::result_t result;
    logic [7:0]        b;
    logic [7:0]        limit;
    logic [8:0]        tries;
    logic              timeout;
    logic              sum_ok;

    assign b       = rx.rx_byte;
    assign accept  = rx.valid && rx.ready;
    assign rx.ready = space;
    assign cfg.ready = 1'b1;

    // a zero limit acts as one try
    assign limit   = (hunt_limit_reg == 8'd0) ? 8'd1 : hunt_limit_reg;
    assign tries   = {1'b0, hunt_count_reg} + 9'd1;
    assign timeout = tries >= {1'b0, limit};
    assign sum_ok  = b == sum_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        hunt_count_next = hunt_count_reg;
        command_next    = command_reg;
        algorithm_next  = algorithm_reg;
        length_next     = length_reg;
        position_next   = position_reg;
        sum_next        = sum_reg;
        load            = 1'b0;
        result          = '0;
        unique case (phase_reg)
            PH_HUNT2:
            begin
                if (b == second_sync_reg)
                begin
                    hunt_count_next = 8'd0;
                    phase_next      = PH_CMD;
                end
                else if (timeout)
                begin
                    hunt_count_next = 8'd0;
                    phase_next      = PH_HUNT1;
                    load            = 1'b1;
                    result.kind     = shfp_pkg::KIND_SECOND_TIMEOUT;
                    result.last     = 1'b1;
                end
                else
                begin
                    hunt_count_next = tries[7:0];
                end
            end
            PH_CMD:
            begin
                command_next = b;
                sum_next     = first_sync_reg + second_sync_reg + b;
                phase_next   = PH_ALGO;
            end
            PH_ALGO:
            begin
                algorithm_next = b;
                sum_next       = sum_reg + b;
                phase_next     = PH_LEN;
            end
            PH_LEN:
            begin
                length_next   = b;
                sum_next      = sum_reg + b;
                position_next = 8'd0;
                phase_next    = (b == 8'd0) ? PH_SUM : PH_DATA;
            end
            PH_DATA:
            begin
                sum_next      = sum_reg + b;
                position_next = position_reg + 8'd1;
                if (position_next == length_reg)
                begin
                    phase_next = PH_SUM;
                end
                load                  = 1'b1;
                result.kind           = shfp_pkg::KIND_PAYLOAD;
                result.data_byte      = b;
                result.byte_index     = position_reg;
                result.command_code   = command_reg;
                result.algorithm_code = algorithm_reg;
                result.payload_length = length_reg;
                result.computed_sum   = sum_next;
            end
            PH_SUM:
            begin
                phase_next            = PH_HUNT1;
                hunt_count_next       = 8'd0;
                position_next         = 8'd0;
                load                  = 1'b1;
                result.kind           = shfp_pkg::KIND_FRAME_END;
                result.command_code   = sum_ok ? command_reg
                                               : command_reg + shfp_pkg::MISMATCH_OFFSET;
                result.algorithm_code = algorithm_reg;
                result.payload_length = length_reg;
                result.received_sum   = b;
                result.computed_sum   = sum_reg;
                result.sum_matches    = sum_ok;
                result.last           = 1'b1;
            end
            default:
            begin
                phase_next = PH_HUNT1;
                if (b == first_sync_reg)
                begin
                    hunt_count_next = 8'd0;
                    phase_next      = PH_HUNT2;
                end
                else if (timeout)
                begin
                    hunt_count_next = 8'd0;
                    load            = 1'b1;
                    result.kind     = shfp_pkg::KIND_FIRST_TIMEOUT;
                    result.last     = 1'b1;
                end
                else
                begin
                    hunt_count_next = tries[7:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT1;
            hunt_count_reg <= 8'd0;
            command_reg    <= 8'd0;
            algorithm_reg  <= 8'd0;
            length_reg     <= 8'd0;
            position_reg   <= 8'd0;
            sum_reg        <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            hunt_count_reg <= hunt_count_next;
            command_reg    <= command_next;
            algorithm_reg  <= algorithm_next;
            length_reg     <= length_next;
            position_reg   <= position_next;
            sum_reg        <= sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_sync_reg  <= shfp_pkg::FIRST_SYNC_RESET;
            second_sync_reg <= shfp_pkg::SECOND_SYNC_RESET;
            hunt_limit_reg  <= shfp_pkg::HUNT_LIMIT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                shfp_pkg::REG_FIRST_SYNC:  first_sync_reg  <= cfg.data;
                shfp_pkg::REG_SECOND_SYNC: second_sync_reg <= cfg.data;
                shfp_pkg::REG_HUNT_LIMIT:  hunt_limit_reg  <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    shfp_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept && load),
        .result (result),
        .space  (space),
        .res    (res)
    );

    // a word still waiting is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |-> !accept)
        else $error("byte accepted while result word stalled");

    // end of frame returns to the first hunt with a cleared count
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_SUM) |=> (phase_reg == PH_HUNT1 && hunt_count_reg == 8'd0))
        else $error("frame end did not restart the hunt");

    // last marks exactly the words that are not payload bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.last == (res.kind != shfp_pkg::KIND_PAYLOAD)))
        else $error("last flag disagrees with result kind");

    // hunt count stays zero outside the hunting phases
    assert property (@(posedge clk) disable iff (!rst_n)
        !(phase_reg == PH_HUNT1 || phase_reg == PH_HUNT2) |-> hunt_count_reg == 8'd0)
        else $error("hunt count left over outside a hunt");

endmodule

FILE: hdl/shfp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfp_out_reg
// Result register: holds one result word until the sink takes it and
// reports whether a new word can be loaded in this cycle.
// ----------------------------------------------------------------------------
module shfp_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  shfp_pkg::result_t   result,
    output logic                space,
    shfp_result_if.source       res
);

    logic              valid_reg;
    logic              valid_next;
    shfp_pkg::result_t data_reg;

    assign space = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res.ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign res.valid          = valid_reg;
    assign res.kind           = data_reg.kind;
    assign res.data_byte      = data_reg.data_byte;
    assign res.byte_index     = data_reg.byte_index;
    assign res.command_code   = data_reg.command_code;
    assign res.algorithm_code = data_reg.algorithm_code;
    assign res.payload_length = data_reg.payload_length;
    assign res.received_sum   = data_reg.received_sum;
    assign res.computed_sum   = data_reg.computed_sum;
    assign res.sum_matches    = data_reg.sum_matches;
    assign res.last           = data_reg.last;

endmodule
